@@ hdl/sah_pkg.sv @@
// Shared types and constants of the LIFO arena allocator.
// Item and result beats, the decoded command, opcode, status and register codes.
// No dependencies.
package sah_pkg;

  // Arena geometry. The header store holds one entry per header slot.
  localparam int ARENA_MAX_BYTES = 65536;
  localparam int HEADER_BYTES    = 8;
  localparam int HDR_SHIFT       = $clog2(HEADER_BYTES);
  localparam int STORE_DEPTH     = ARENA_MAX_BYTES / HEADER_BYTES;
  localparam int IDX_W           = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int OFF_W   = 17;
  localparam int ADDR_W  = 32;
  localparam int LG_W    = 4;
  localparam int MASK_W  = 15;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Opcodes.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;
  localparam logic [1:0] OP_REWIND = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SPACE    = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY   = 2'd2;
  localparam logic [1:0] ST_REWIND_HIGH = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BYTES  = 1'd1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [OFF_W-1:0] alloc_size;
    logic [LG_W-1:0]  align_log2;
    logic [OFF_W-1:0] rewind_target;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [OFF_W-1:0]  top_offset;
  } out_item_t;

  // Command as the front end hands it over: operands that do not depend on
  // the top are already formed.
  typedef struct packed {
    logic [1:0]        op;
    logic [MASK_W-1:0] align_mask;     // alignment minus one
    logic [ADDR_W:0]   base_mask;      // base plus alignment mask
    logic [OFF_W:0]    size_rnd;       // size plus header rounding slack
    logic [ADDR_W:0]   limit;          // absolute end of the usable arena
    logic [OFF_W-1:0]  rewind_target;
  } cmd_t;

endpackage

@@ hdl/sah_queue.sv @@
// Small synchronous FIFO used between the front and back ends and for results.
// Payload type and depth are parameters; no package dependency.
module sah_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T                entries [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/sah_front.sv @@
// Front end: takes input beats and turns them into commands for the back end.
// Depends on sah_pkg.
module sah_front (
  input  logic                          in_push,
  input  sah_pkg::in_item_t             in_data,
  output logic                          in_full,
  input  logic [sah_pkg::ADDR_W-1:0]    base_address,
  input  logic [sah_pkg::OFF_W-1:0]     arena_bytes,
  output logic                          q_push,
  output sah_pkg::cmd_t                 q_data,
  input  logic                          q_full
);

  logic [sah_pkg::MASK_W:0]    mask_wide;
  logic [sah_pkg::OFF_W-1:0]   usable;

  // An arena larger than the header store can cover is clipped to it.
  assign usable = (arena_bytes > sah_pkg::OFF_W'(sah_pkg::ARENA_MAX_BYTES))
                  ? sah_pkg::OFF_W'(sah_pkg::ARENA_MAX_BYTES) : arena_bytes;

  assign mask_wide = ({{sah_pkg::MASK_W{1'b0}}, 1'b1} << in_data.align_log2)
                     - {{sah_pkg::MASK_W{1'b0}}, 1'b1};

  always_comb begin
    q_data.op            = in_data.opcode;
    q_data.align_mask    = mask_wide[sah_pkg::MASK_W-1:0];
    q_data.base_mask     = {1'b0, base_address}
                           + {{(sah_pkg::ADDR_W + 1 - sah_pkg::MASK_W){1'b0}},
                              mask_wide[sah_pkg::MASK_W-1:0]};
    q_data.size_rnd      = {1'b0, in_data.alloc_size}
                           + (sah_pkg::OFF_W + 1)'(sah_pkg::HEADER_BYTES - 1);
    q_data.limit         = {1'b0, base_address}
                           + {{(sah_pkg::ADDR_W + 1 - sah_pkg::OFF_W){1'b0}}, usable};
    q_data.rewind_target = in_data.rewind_target;
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

@@ hdl/sah_back.sv @@
// Back end: holds the top offset and the header store and executes commands.
// Depends on sah_pkg.
module sah_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sah_pkg::ADDR_W-1:0]    base_address,
  input  sah_pkg::cmd_t                 cmd,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  output logic                          res_push,
  output sah_pkg::out_item_t            res_data,
  input  logic                          res_full
);

  localparam int OffW  = sah_pkg::OFF_W;
  localparam int AddrW = sah_pkg::ADDR_W;
  localparam int IdxW  = sah_pkg::IDX_W;
  localparam int Shift = sah_pkg::HDR_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_ALIGN, S_PLACE, S_POP_RD} state_t;

  state_t              state_r, state_nxt;
  logic [OffW-1:0]     top_r, top_nxt;
  logic [AddrW+1:0]    aligned_r, aligned_nxt;
  logic [AddrW+2:0]    hdr_r, hdr_nxt;
  sah_pkg::cmd_t       cmd_r, cmd_nxt;

  logic [OffW-1:0]     store [sah_pkg::STORE_DEPTH];
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [OffW-1:0]     mem_wdata;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  logic [OffW-1:0]     rd_data_r;

  logic [AddrW+1:0]    cur_sum;
  logic [AddrW+2:0]    hdr_sum;
  logic [AddrW+3:0]    next_abs;
  logic [AddrW+2:0]    hdr_off;
  logic [OffW-1:0]     new_top;
  logic [OffW-Shift-1:0] pop_slot;
  logic                fits;

  assign cur_sum  = {1'b0, cmd.base_mask} + {{(AddrW + 2 - OffW){1'b0}}, top_r};
  assign hdr_sum  = {1'b0, aligned_r}
                    + {{(AddrW + 2 - OffW){1'b0}}, cmd_r.size_rnd};
  assign next_abs = {1'b0, hdr_r} + (AddrW + 4)'(sah_pkg::HEADER_BYTES);
  assign hdr_off  = hdr_r - {3'b000, base_address};
  assign new_top  = hdr_off[OffW-1:0] + OffW'(sah_pkg::HEADER_BYTES);
  assign fits     = !(next_abs > {3'b000, cmd_r.limit});
  assign pop_slot = top_r[OffW-1:Shift] - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    top_nxt     = top_r;
    aligned_nxt = aligned_r;
    hdr_nxt     = hdr_r;
    cmd_nxt     = cmd_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_data.status        = sah_pkg::ST_OK;
    res_data.block_address = '0;
    res_data.top_offset    = top_r;
    mem_we      = 1'b0;
    mem_waddr   = hdr_off[Shift+IdxW-1:Shift];
    mem_wdata   = top_r;
    mem_re      = 1'b0;
    mem_raddr   = pop_slot[IdxW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          unique case (cmd.op)
            sah_pkg::OP_ALLOC: begin
              aligned_nxt = cur_sum & ~{{(AddrW + 2 - sah_pkg::MASK_W){1'b0}},
                                        cmd.align_mask};
              state_nxt   = S_ALIGN;
            end
            sah_pkg::OP_POP: begin
              if (top_r == '0) begin
                res_push        = 1'b1;
                res_data.status = sah_pkg::ST_POP_EMPTY;
              end else if (top_r[OffW-1:Shift] == '0) begin
                top_nxt             = '0;
                res_push            = 1'b1;
                res_data.top_offset = '0;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_POP_RD;
              end
            end
            sah_pkg::OP_RESET: begin
              top_nxt             = '0;
              res_push            = 1'b1;
              res_data.top_offset = '0;
            end
            sah_pkg::OP_REWIND: begin
              res_push = 1'b1;
              if (cmd.rewind_target > top_r) begin
                res_data.status = sah_pkg::ST_REWIND_HIGH;
              end else begin
                top_nxt             = cmd.rewind_target;
                res_data.top_offset = cmd.rewind_target;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ALIGN: begin
        hdr_nxt   = hdr_sum & ~(AddrW + 3)'(sah_pkg::HEADER_BYTES - 1);
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
        if (fits) begin
          mem_we                 = 1'b1;
          top_nxt                = new_top;
          res_data.block_address = aligned_r[AddrW-1:0];
          res_data.top_offset    = new_top;
        end else begin
          res_data.status = sah_pkg::ST_NO_SPACE;
        end
      end
      S_POP_RD: begin
        top_nxt             = rd_data_r;
        res_push            = 1'b1;
        res_data.top_offset = rd_data_r;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      top_r     <= top_nxt;
      aligned_r <= aligned_nxt;
      hdr_r     <= hdr_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  // Header store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= store[mem_raddr];
    end
  end

endmodule

@@ hdl/stack_allocator_with_headers.sv @@
// Top level of the LIFO arena allocator with per-block headers.
// Depends on sah_pkg, sah_front, sah_queue and sah_back.

// The allocator keeps a top offset into an arena that starts at base_address
// and spans arena_bytes bytes (clipped to 64 KiB). Each input beat carries one
// command and produces exactly one result beat, in order. An alloc rounds the
// absolute top up to 2^align_log2, places an 8-byte header at the next
// 8-byte boundary after the block, stores the old top there and moves the top
// past the header; if that would pass the arena end it returns no-space with
// address 0. A pop restores the top from the header that ends at the top,
// reset clears the top, and rewind moves the top down to a marker. Every
// result carries the top offset after the command. Commands enter a two-beat
// queue, so the input keeps taking beats while the back end works, and results
// wait in a two-beat queue, so the back end can run two results ahead of a
// slow consumer before the input backs up.
// The back end is a sequencer that runs one command at a time: reset, rewind
// and a pop that needs no header complete in the idle state, a pop that reads
// a header adds a state for the registered header memory read, and an alloc
// steps through align, place the header, and check the fit and commit. A
// command is registered in the command queue before the back end reads it,
// and a result is registered in the result queue before it can be popped.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while the block is idle, as the block does not enforce this;
// index 0 is base_address and index 1 is arena_bytes. The header store is not
// cleared at reset, and a pop of a header that was never written returns an
// unspecified top.
module stack_allocator_with_headers (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  sah_pkg::in_item_t                in_data,
  output logic                             in_full,
  input  logic                             out_pop,
  output sah_pkg::out_item_t               out_data,
  output logic                             out_empty,
  input  logic                             cfg_we,
  input  logic [sah_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sah_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [sah_pkg::ADDR_W-1:0] base_address_r;
  logic [sah_pkg::OFF_W-1:0]  arena_bytes_r;

  logic                q_push;
  sah_pkg::cmd_t       q_data;
  logic                q_full;
  sah_pkg::cmd_t       cmd_head;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_push;
  sah_pkg::out_item_t  res_data;
  logic                res_full;

  // Configuration registers. The top offset is kept across changes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= '0;
      arena_bytes_r  <= sah_pkg::OFF_W'(sah_pkg::ARENA_MAX_BYTES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sah_pkg::CFG_BASE_ADDRESS: base_address_r <= cfg_wdata[sah_pkg::ADDR_W-1:0];
        sah_pkg::CFG_ARENA_BYTES:  arena_bytes_r  <= cfg_wdata[sah_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end decodes each beat and forms the operands that do not
  // depend on the top.
  sah_front u_front (
    .in_push      (in_push),
    .in_data      (in_data),
    .in_full      (in_full),
    .base_address (base_address_r),
    .arena_bytes  (arena_bytes_r),
    .q_push       (q_push),
    .q_data       (q_data),
    .q_full       (q_full)
  );

  sah_queue #(
    .T     (sah_pkg::cmd_t),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  // The back end starts a command only when the result queue has room, so
  // its result is always taken when it finishes.
  sah_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_address (base_address_r),
    .cmd          (cmd_head),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .res_push     (res_push),
    .res_data     (res_data),
    .res_full     (res_full)
  );

  sah_queue #(
    .T     (sah_pkg::out_item_t),
    .DEPTH (2)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

@@ dv/sah_result_checker.sv @@
// Result checker for the LIFO arena allocator: tracks the arena state and
// compares every result beat with the predicted one.
// Depends on sah_pkg for the beat types, opcodes, status and register codes.
module sah_result_checker
  import sah_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  in_item_t             in_data,
  input  logic                 out_pop,
  input  logic                 out_empty,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  // Shadow copy of the configuration and of the arena state.
  logic [ADDR_W-1:0] base_reg;
  logic [OFF_W-1:0]  arena_reg;
  logic [OFF_W-1:0]  top_pred;
  logic [OFF_W-1:0]  hdr_pred [STORE_DEPTH];

  out_item_t expected_results [$];
  int        n_fail = 0;

  always @(posedge clk) begin : track_and_check
    logic [63:0] usable, align, cur, aligned, hdr_abs, next_abs;
    out_item_t   exp_res, new_res;
    if (!rst_n) begin
      base_reg  = '0;
      arena_reg = OFF_W'(ARENA_MAX_BYTES);
      top_pred  = '0;
      expected_results.delete();
      n_fail = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE_ADDRESS) begin
          base_reg = cfg_wdata;
        end else if (cfg_index == CFG_ARENA_BYTES) begin
          arena_reg = cfg_wdata[OFF_W-1:0];
        end
      end

      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command waiting: status %0d, address %h, top %h",
                 out_data.status, out_data.block_address, out_data.top_offset);
          n_fail++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
            n_fail++;
          end
          if (out_data.block_address !== exp_res.block_address) begin
            $error("block_address: expected %h, got %h",
                   exp_res.block_address, out_data.block_address);
            n_fail++;
          end
          if (out_data.top_offset !== exp_res.top_offset) begin
            $error("top_offset: expected %h, got %h", exp_res.top_offset, out_data.top_offset);
            n_fail++;
          end
        end
      end

      if (in_push && !in_full) begin
        new_res = '0;
        new_res.status = ST_OK;
        case (in_data.opcode)
          OP_ALLOC: begin
            // Work in 64 bits so that an arena crossing 2^32 keeps its carry.
            usable   = (arena_reg > OFF_W'(ARENA_MAX_BYTES)) ? 64'(ARENA_MAX_BYTES)
                                                             : 64'(arena_reg);
            align    = 64'd1 << in_data.align_log2;
            cur      = 64'(base_reg) + 64'(top_pred);
            aligned  = (cur + align - 64'd1) & ~(align - 64'd1);
            hdr_abs  = aligned + 64'(in_data.alloc_size);
            hdr_abs  = (hdr_abs + 64'(HEADER_BYTES - 1)) & ~64'(HEADER_BYTES - 1);
            next_abs = hdr_abs + 64'(HEADER_BYTES);
            if (next_abs > 64'(base_reg) + usable) begin
              new_res.status = ST_NO_SPACE;
            end else begin
              hdr_pred[IDX_W'((hdr_abs - 64'(base_reg)) >> HDR_SHIFT)] = top_pred;
              top_pred = OFF_W'(next_abs - 64'(base_reg));
              new_res.block_address = aligned[ADDR_W-1:0];
            end
          end
          OP_POP: begin
            if (top_pred == '0) begin
              new_res.status = ST_POP_EMPTY;
            end else if (top_pred < OFF_W'(HEADER_BYTES)) begin
              top_pred = '0;
            end else begin
              top_pred = hdr_pred[IDX_W'((top_pred - OFF_W'(HEADER_BYTES)) >> HDR_SHIFT)];
            end
          end
          OP_RESET: begin
            top_pred = '0;
          end
          OP_REWIND: begin
            if (in_data.rewind_target > top_pred) begin
              new_res.status = ST_REWIND_HIGH;
            end else begin
              top_pred = in_data.rewind_target;
            end
          end
          default: ;
        endcase
        new_res.top_offset = top_pred;
        expected_results.push_back(new_res);
      end
    end
    fail_count <= n_fail;
    pending    <= expected_results.size();
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for stack_allocator_with_headers: clock, reset, command and
// configuration stimulus, result consumer, watchdog and the final verdict.
// Depends on sah_pkg, the allocator RTL and sah_result_checker.
module tb_top;
  import sah_pkg::*;

  // Cycles the back end may still need after the last result (alloc plus queue).
  localparam int DRAIN_GAP     = 8;
  // Length of the deliberate consumer hold-off that fills the block up.
  localparam int HOLD_CYCLES   = 300;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int WATCHDOG_MAX  = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 40;
  // Header slots written right after reset. Rewind targets stay at or below the end
  // of this region or above any possible top.
  localparam int FILL_SLOTS    = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_push = 1'b0;
  in_item_t             in_data = '0;
  logic                 in_full;
  logic                 out_pop = 1'b0;
  out_item_t            out_data;
  logic                 out_empty;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int pending;

  // Idling knobs, in percent per cycle. The sender's is used only by the
  // stimulus process; the receiver's is handed over with a nonblocking write.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // A toggle of hold_req asks the receiver for one long hold-off.
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int idle_cycles = 0;

  always #4 clk = ~clk;

  stack_allocator_with_headers u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sah_result_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result consumer. It pops at random according to recv_stall_pct, and on
  // request holds off, counting down from HOLD_CYCLES, so that both internal
  // queues fill and the block raises in_full against a busy sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_pop   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted beat or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("** stack_allocator_with_headers: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_cmd(input logic [1:0] op, input logic [OFF_W-1:0] size,
                                        input logic [LG_W-1:0] lg,
                                        input logic [OFF_W-1:0] target);
    in_item_t c;
    c.opcode        = op;
    c.alloc_size    = size;
    c.align_log2    = lg;
    c.rewind_target = target;
    return c;
  endfunction

  // A command of the given opcode with every field filled in. Sizes lean
  // small so that allocs mostly fit, but all 17 bits still toggle now and
  // then. A rewind target either lies in the low region whose headers are
  // written right after reset, or above any top the arena allows, so that
  // every pop reads a header that was written. Fields that the opcode does
  // not use carry random values too.
  function automatic in_item_t random_cmd(input logic [1:0] op);
    in_item_t    c;
    int unsigned pick;
    c.opcode = op;
    pick = $urandom_range(99);
    if (pick < 75) begin
      c.alloc_size = OFF_W'($urandom_range(0, 64));
    end else if (pick < 95) begin
      c.alloc_size = OFF_W'($urandom_range(0, 4096));
    end else begin
      c.alloc_size = OFF_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      c.align_log2 = LG_W'($urandom_range(0, 4));
    end else if (pick < 90) begin
      c.align_log2 = LG_W'($urandom_range(5, 12));
    end else begin
      c.align_log2 = LG_W'($urandom_range(13, 15));
    end
    if ($urandom_range(99) < 70) begin
      c.rewind_target = OFF_W'($urandom_range(0, HEADER_BYTES * FILL_SLOTS));
    end else begin
      c.rewind_target = OFF_W'($urandom_range(ARENA_MAX_BYTES + 1, 131071));
    end
    return c;
  endfunction

  // Offer one command beat and return at the edge where it is taken. The
  // sender may idle first; push stays high from one beat to the next when
  // there is no gap, so it never gets two assignments in one step.
  task automatic send_item(input in_item_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_full);
  endtask

  // Stop sending and wait until every predicted result has been consumed.
  // The first edge lets the checker count a beat taken at the current edge.
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Both registers, one per cycle, with the enable held across the pair.
  // Bits of the size word above the register width are written as noise.
  task automatic set_arena(input logic [ADDR_W-1:0] base, input logic [OFF_W-1:0] bytes);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_ARENA_BYTES;
    cfg_wdata <= {(CFG_W - OFF_W)'($urandom), bytes};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly nested alloc/pop sequences, so that pops unwind real headers, with
  // an occasional rewind inside a sequence and single random commands as
  // noise. Now and then the sender pauses until the block has gone quiet.
  task automatic run_traffic(input int n_items);
    int sent;
    int depth;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        depth = $urandom_range(1, 6);
        for (int k = 0; k < depth; k++) send_item(random_cmd(OP_ALLOC));
        if ($urandom_range(99) < 20) begin
          send_item(random_cmd(OP_REWIND));
          sent++;
        end
        for (int k = 0; k < depth; k++) send_item(random_cmd(OP_POP));
        sent += 2 * depth;
      end else begin
        send_item(random_cmd(2'($urandom_range(0, 3))));
        sent++;
      end
      if ($urandom_range(99) < 3) wait_drained();
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    logic [OFF_W-1:0]  bytes;
    int                mode;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The header store comes out of reset undefined. Empty allocs from the
    // base write the low header slots once, so that a rewind into that region
    // is always followed by pops that read defined headers. Every other top
    // is reached by an alloc that writes its own header.
    for (int i = 0; i < FILL_SLOTS; i++) begin
      send_item(make_cmd(OP_ALLOC, '0, '0, OFF_W'($urandom)));
    end

    // Directed corners at the reset configuration.
    send_item(make_cmd(OP_RESET,  17'h1FFFF,   4'hF,  17'h1FFFF));
    send_item(make_cmd(OP_POP,    17'd0,       4'd0,  17'd0));       // pop on empty
    send_item(make_cmd(OP_ALLOC,  17'h1FFFF,   4'd15, 17'd0));       // oversized request
    send_item(make_cmd(OP_ALLOC,  17'd65536,   4'd0,  17'd0));       // one header too big
    send_item(make_cmd(OP_ALLOC,  17'd65528,   4'd0,  17'd0));       // exact fit
    send_item(make_cmd(OP_ALLOC,  17'd0,       4'd0,  17'd0));       // full: no space
    send_item(make_cmd(OP_REWIND, 17'd0,       4'd0,  17'h1FFFF));   // target above top
    send_item(make_cmd(OP_REWIND, 17'd0,       4'd0,  17'h10000));   // target equals top
    send_item(make_cmd(OP_POP,    17'd0,       4'd0,  17'd0));
    send_item(make_cmd(OP_ALLOC,  17'd0,       4'd0,  17'd0));
    send_item(make_cmd(OP_REWIND, 17'd0,       4'd0,  17'd5));
    send_item(make_cmd(OP_POP,    17'd0,       4'd0,  17'd0));       // top below header size
    send_item(make_cmd(OP_ALLOC,  17'd1,       4'd0,  17'd0));
    send_item(make_cmd(OP_ALLOC,  17'd100,     4'd15, 17'd0));       // largest alignment
    send_item(make_cmd(OP_ALLOC,  17'd7,       4'd12, 17'd0));
    send_item(make_cmd(OP_ALLOC,  17'd24,      4'd4,  17'd0));       // malloc alignment
    send_item(make_cmd(OP_ALLOC,  17'd3,       4'd1,  17'd0));
    send_item(make_cmd(OP_POP,    17'd0,       4'd0,  17'd0));
    send_item(make_cmd(OP_REWIND, 17'd0,       4'd0,  17'd16));
    send_item(make_cmd(OP_POP,    17'd0,       4'd0,  17'd0));
    send_item(make_cmd(OP_REWIND, 17'd0,       4'd0,  17'd0));

    // Random phases. Each one starts from an idle block with a new arena; the
    // top offset carries over, as it does in the block. Idling modes rotate
    // through none, sender only, receiver only and both.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin base = 32'h0000_0000; bytes = 17'h10000; end
        1: begin base = 32'h1234_5673; bytes = 17'd16;    end  // smallest, unaligned
        2: begin base = 32'hFFFF_FFF0; bytes = 17'h10000; end  // wraps past 2^32
        3: begin base = 32'hFFFF_FFFF; bytes = 17'h1FFFF; end  // oversized, clipped
        4: begin base = 32'h8000_0000; bytes = 17'd4096;  end
        default: begin
          base  = $urandom;
          bytes = OFF_W'($urandom_range(16, 65536));
        end
      endcase
      wait_drained();
      set_arena(base, bytes);
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 27 : 0;
      recv_stall_pct <= (mode == 2) ? 61 : (mode == 3) ? 27 : 0;
      // One phase opens with the consumer held off while the sender keeps
      // offering beats back to back.
      if (p == 4) hold_req <= ~hold_req;
      run_traffic(PHASE_ITEMS);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("** stack_allocator_with_headers: PASSED **");
    end else begin
      $display("** stack_allocator_with_headers: FAILED **");
    end
    $finish;
  end

endmodule

@@ stack_allocator_with_headers.f @@
hdl/sah_pkg.sv
hdl/sah_queue.sv
hdl/sah_front.sv
hdl/sah_back.sv
hdl/stack_allocator_with_headers.sv
dv/sah_result_checker.sv
dv/tb_top.sv
